FILE: rtl/core/crcdf_pkg.sv
package crcdf_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CRC_W  = 16;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_START_MARKER = 2'd0;
    localparam cfg_index_t CFG_END_MARKER   = 2'd1;
    localparam cfg_index_t CFG_LENGTH_LIMIT = 2'd2;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_GOOD      = 2'd0;
    localparam status_t ST_CRC_ERR   = 2'd1;
    localparam status_t ST_LEN_ERR   = 2'd2;
    localparam status_t ST_END_ERR   = 2'd3;

    // CRC-16/X-25 constants (reflected form).
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

    // Saturation value for an oversized length report.
    localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

    // Delivery request handed from the parser to the emitter.
    typedef struct packed {
        logic               fire;
        logic               run;
        status_t            status;
        logic [BYTE_W-1:0]  cmd;
        logic [LEN_W-1:0]   len;
    } job_t;

    // One byte of the reflected CRC update, eight shift steps.
    function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/crcdf_payload_mem.sv
module crcdf_payload_mem
    import crcdf_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/crcdf_parser.sv
module crcdf_parser
    import crcdf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int ADDR_W      = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_marker,
    input  logic [BYTE_W-1:0] end_marker,
    input  logic [LEN_W-1:0]  length_limit,
    output job_t              job,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [BYTE_W-1:0] wr_data
);

    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_END     = 5'b10000
    } phase_t;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    phase_t             phase_reg, phase_next;
    logic [1:0]         hpos_reg, hpos_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   bpos_reg, bpos_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [CRC_W-1:0]   chk_reg, chk_next;

    logic [LEN_W-1:0]   limit;
    logic [CRC_W-1:0]   crc_fed;
    logic               too_large;
    logic [LEN_W-1:0]   sat_len;
    logic [LEN_W-1:0]   bpos_inc;

    // The effective limit never exceeds the store depth.
    assign limit    = (length_limit < MAX_LEN) ? length_limit : MAX_LEN;
    assign crc_fed  = crc16_feed(crc_reg, rx_byte);
    assign bpos_inc = bpos_reg + 7'd1;

    // Length checks on the full 16-bit value: high byte plus held low byte.
    assign too_large = (rx_byte != 8'h00) || ({1'b0, len_lo_reg} > {2'b00, limit});
    assign sat_len   = ((rx_byte != 8'h00) || len_lo_reg[7]) ? LEN_SAT : len_lo_reg[6:0];

    // Parse sequencer, one byte per accepted beat.
    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        cmd_next    = cmd_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        bpos_next   = bpos_reg;
        crc_next    = crc_reg;
        chk_next    = chk_reg;
        job         = '0;
        job.cmd     = cmd_reg;
        job.len     = len_reg;
        wr_en       = 1'b0;
        wr_addr     = bpos_reg[ADDR_W-1:0];
        wr_data     = rx_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == start_marker)
                    begin
                        phase_next = PH_HEADER;
                        hpos_next  = 2'd0;
                        crc_next   = CRC_INIT;
                    end
                end
                PH_HEADER:
                begin
                    crc_next = crc_fed;
                    case (hpos_reg)
                        2'd0:
                        begin
                            cmd_next  = rx_byte;
                            hpos_next = 2'd1;
                        end
                        2'd1:
                        begin
                            len_lo_next = rx_byte;
                            hpos_next   = 2'd2;
                        end
                        default:
                        begin
                            hpos_next = 2'd0;
                            bpos_next = '0;
                            if (too_large)
                            begin
                                job.fire   = 1'b1;
                                job.status = ST_LEN_ERR;
                                job.len    = sat_len;
                                phase_next = PH_WAIT;
                            end
                            else
                            begin
                                len_next   = len_lo_reg[6:0];
                                phase_next = (len_lo_reg != 8'h00) ? PH_PAYLOAD : PH_CRC;
                            end
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    crc_next  = crc_fed;
                    wr_en     = 1'b1;
                    bpos_next = bpos_inc;
                    if (bpos_inc >= len_reg)
                    begin
                        phase_next = PH_CRC;
                        hpos_next  = 2'd0;
                    end
                end
                PH_CRC:
                begin
                    if (hpos_reg == 2'd0)
                    begin
                        chk_next  = {8'h00, rx_byte};
                        hpos_next = 2'd1;
                    end
                    else
                    begin
                        chk_next   = {rx_byte, chk_reg[7:0]};
                        hpos_next  = 2'd0;
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    job.fire = 1'b1;
                    if (rx_byte == end_marker)
                    begin
                        phase_next = PH_WAIT;
                        if (~crc_reg == chk_reg)
                        begin
                            job.status = ST_GOOD;
                            job.run    = (len_reg != '0);
                        end
                        else
                        begin
                            job.status = ST_CRC_ERR;
                        end
                    end
                    else
                    begin
                        job.status = ST_END_ERR;
                        // A start byte in the end slot opens the next frame at once.
                        if (rx_byte == start_marker)
                        begin
                            phase_next = PH_HEADER;
                            hpos_next  = 2'd0;
                            crc_next   = CRC_INIT;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            hpos_reg   <= '0;
            cmd_reg    <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
            bpos_reg   <= '0;
            crc_reg    <= CRC_INIT;
            chk_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            cmd_reg    <= cmd_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
            bpos_reg   <= bpos_next;
            crc_reg    <= crc_next;
            chk_reg    <= chk_next;
        end
    end

    // Payload writes stay inside the announced length.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (bpos_reg < len_reg))
    else $error("payload write beyond frame length");

    // A delivery request only comes from an accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        job.fire |-> accept)
    else $error("delivery request without an accepted beat");

endmodule

FILE: rtl/core/crcdf_emitter.sv
module crcdf_emitter
    import crcdf_pkg::*;
#(
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              job,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic              item_stall,
    output logic              item_valid,
    output logic [1:0]        status,
    output logic [BYTE_W-1:0] frame_cmd,
    output logic [LEN_W-1:0]  frame_len,
    output logic [BYTE_W-1:0] data_byte,
    output logic              byte_valid,
    output logic              last
);

    logic              valid_reg, valid_next;
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              bvalid_reg, bvalid_next;
    logic              last_reg, last_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              take;
    logic [LEN_W-1:0]  idx_inc;

    assign take    = valid_reg && !item_stall;
    assign idx_inc = idx_reg + 7'd1;

    // Delivery sequencer; the memory read register doubles as the data output stage.
    always_comb
    begin
        valid_next  = valid_reg;
        status_next = status_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        if (job.fire)
        begin
            valid_next  = 1'b1;
            status_next = job.status;
            cmd_next    = job.cmd;
            len_next    = job.len;
            idx_next    = '0;
            bvalid_next = job.run;
            last_next   = job.run ? (job.len == 7'd1) : 1'b1;
            rd_en       = job.run;
        end
        else if (take)
        begin
            if (last_reg)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next  = idx_inc;
                rd_en     = 1'b1;
                rd_addr   = idx_inc[ADDR_W-1:0];
                last_next = ((idx_inc + 7'd1) == len_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= ST_GOOD;
            cmd_reg    <= '0;
            len_reg    <= '0;
            bvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            status_reg <= status_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            bvalid_reg <= bvalid_next;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
        end
    end

    assign item_valid = valid_reg;
    assign status     = status_reg;
    assign frame_cmd  = cmd_reg;
    assign frame_len  = len_reg;
    assign data_byte  = bvalid_reg ? rd_data : 8'h00;
    assign byte_valid = bvalid_reg;
    assign last       = last_reg;

    // A new request never lands on a beat that is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        job.fire |-> !valid_reg)
    else $error("delivery request while a beat is pending");

    // A run continues after every beat but its last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_reg) |=> (valid_reg && bvalid_reg))
    else $error("payload run ended early");

endmodule

FILE: rtl/core/crc16_frame_deframer_unit.sv
// Latency: an error beat, or the first beat of a good frame, is shown the cycle after the
// closing byte (for a length error, the length high byte) is accepted; payload beats then
// follow one per cycle from the store while item_stall is low. Throughput: one received
// byte per cycle; rx_stall stays high while a result beat pends, so input waits out each delivery.
// Reset: rst_n clears the parser, emitter and markers to defaults at once; the payload
// store is not cleared and needs no clearing pass.
module crc16_frame_deframer_unit
    import crcdf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    output logic              item_valid,
    input  logic              item_stall,
    output logic [1:0]        status,
    output logic [7:0]        frame_cmd,
    output logic [6:0]        frame_len,
    output logic [7:0]        data_byte,
    output logic              byte_valid,
    output logic              last,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic [LEN_W-1:0]  length_limit_reg;

    logic              accept;
    job_t              job;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= 8'hAA;
            end_marker_reg   <= 8'h55;
            length_limit_reg <= 7'd64;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_wdata;
                CFG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                CFG_LENGTH_LIMIT: length_limit_reg <= cfg_wdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // The store is only read during delivery, so input holds off until it ends.
    assign rx_stall = item_valid;
    assign accept   = rx_valid && !rx_stall;

    crcdf_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .length_limit (length_limit_reg),
        .job          (job),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    crcdf_payload_mem #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crcdf_emitter #(
        .ADDR_W (ADDR_W)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .rd_data    (rd_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_stall (item_stall),
        .item_valid (item_valid),
        .status     (status),
        .frame_cmd  (frame_cmd),
        .frame_len  (frame_len),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

endmodule
